// File: design/pbu_pkg.sv
// Package for the pixel blend unit: blend command codes, configuration
// register indexes and the payload structs that pass between pipeline stages.
// No dependencies.
package pbu_pkg;

  typedef logic [3:0] cmd_t;

  localparam cmd_t CMD_MIX   = 4'd0;
  localparam cmd_t CMD_ADD   = 4'd1;
  localparam cmd_t CMD_SUB   = 4'd2;
  localparam cmd_t CMD_OVER  = 4'd3;
  localparam cmd_t CMD_EXCL  = 4'd4;
  localparam cmd_t CMD_SOFT  = 4'd5;
  localparam cmd_t CMD_DARK  = 4'd6;
  localparam cmd_t CMD_MUL   = 4'd7;
  localparam cmd_t CMD_MULA  = 4'd8;
  localparam cmd_t CMD_MIXA  = 4'd9;
  localparam cmd_t CMD_FADE  = 4'd10;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MIX_ALPHA  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FADE_COLOR = 2'd1;

  localparam int LANES  = 4;
  localparam int PROD_W = 17;

  // Accepted input transaction.
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] src;
    logic [31:0] dst;
    logic        last;
  } in_item_t;

  // Operand stage output: multiplier operands per byte lane.
  typedef struct packed {
    cmd_t                  cmd;
    logic [31:0]           src;
    logic [31:0]           dst;
    logic                  last;
    logic [LANES-1:0][7:0] direct;
    logic [LANES-1:0][7:0] x0;
    logic [LANES-1:0][8:0] y0;
    logic [LANES-1:0][7:0] x1;
    logic [LANES-1:0][8:0] y1;
  } op_stage_t;

  // Multiply stage output: registered products per byte lane.
  typedef struct packed {
    cmd_t                         cmd;
    logic [31:0]                  src;
    logic [31:0]                  dst;
    logic                         last;
    logic [LANES-1:0][7:0]        direct;
    logic [LANES-1:0][PROD_W-1:0] p0;
    logic [LANES-1:0][PROD_W-1:0] p1;
  } mul_stage_t;

endpackage

// File: design/pbu_if.sv
// Valid/ready channel interfaces for the pixel blend unit.
// Depends on pbu_pkg for the command type.
interface pbu_in_if;
  logic           valid;
  logic           ready;
  pbu_pkg::cmd_t  command;
  logic [31:0]    src_pixel;
  logic [31:0]    dst_pixel;
  logic           last_pixel;

  modport source (output valid, command, src_pixel, dst_pixel, last_pixel, input ready);
  modport sink   (input valid, command, src_pixel, dst_pixel, last_pixel, output ready);
endinterface

interface pbu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;
  logic        last_out;

  modport source (output valid, result_pixel, last_out, input ready);
  modport sink   (input valid, result_pixel, last_out, output ready);
endinterface

// File: design/pbu_operand.sv
// First pipeline stage: picks multiplier operands per byte lane and computes
// the results that need no multiply (add, sub, darken). Depends on pbu_pkg.
module pbu_operand (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbu_pkg::in_item_t   in_data,
  input  logic [7:0]          mix_alpha,
  input  logic [31:0]         fade_color,
  output logic                out_valid,
  input  logic                out_ready,
  output pbu_pkg::op_stage_t  out_data
);

  logic               valid_r;
  pbu_pkg::op_stage_t data_r;
  pbu_pkg::op_stage_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    logic [7:0] sa;
    logic [7:0] sb;
    logic [7:0] db;
    logic [7:0] fb;
    logic [7:0] k;
    logic [7:0] mn;
    logic [8:0] sum;
    logic [8:0] dk;
    sa = in_data.src[31:24];
    data_nxt        = '0;
    data_nxt.cmd    = in_data.cmd;
    data_nxt.src    = in_data.src;
    data_nxt.dst    = in_data.dst;
    data_nxt.last   = in_data.last;
    for (int i = 0; i < pbu_pkg::LANES; i++) begin
      sb  = in_data.src[8*i +: 8];
      db  = in_data.dst[8*i +: 8];
      fb  = fade_color[8*i +: 8];
      k   = {1'b0, sb[7:1]} + 8'd64;
      mn  = (sb < db) ? sb : db;
      sum = {1'b0, sb} + {1'b0, db};
      dk  = {1'b0, db} + {1'b0, mn};
      unique case (in_data.cmd) inside
        pbu_pkg::CMD_MIX: begin
          data_nxt.x0[i] = db;
          data_nxt.y0[i] = 9'd256 - {1'b0, mix_alpha};
          data_nxt.x1[i] = sb;
          data_nxt.y1[i] = {1'b0, mix_alpha};
        end
        pbu_pkg::CMD_MIXA: begin
          data_nxt.x0[i] = db;
          data_nxt.y0[i] = 9'd256 - {1'b0, sa};
          data_nxt.x1[i] = sb;
          data_nxt.y1[i] = {1'b0, sa};
        end
        pbu_pkg::CMD_FADE: begin
          data_nxt.x0[i] = db;
          data_nxt.y0[i] = 9'd256 - {1'b0, mix_alpha};
          data_nxt.x1[i] = fb;
          data_nxt.y1[i] = {1'b0, mix_alpha};
        end
        pbu_pkg::CMD_OVER: begin
          data_nxt.x0[i] = sb;
          data_nxt.y0[i] = {1'b0, sa};
          data_nxt.x1[i] = db;
          data_nxt.y1[i] = {1'b0, 8'd255 - sa};
        end
        pbu_pkg::CMD_EXCL, pbu_pkg::CMD_MUL: begin
          data_nxt.x0[i] = sb;
          data_nxt.y0[i] = {1'b0, db};
        end
        pbu_pkg::CMD_MULA: begin
          data_nxt.x0[i] = sa;
          data_nxt.y0[i] = {1'b0, db};
        end
        pbu_pkg::CMD_SOFT: begin
          // dark half scales k*d, light half scales the complements
          if (!db[7]) begin
            data_nxt.x0[i] = k;
            data_nxt.y0[i] = {1'b0, db};
          end else begin
            data_nxt.x0[i] = 8'd255 - k;
            data_nxt.y0[i] = {1'b0, 8'd255 - db};
          end
        end
        pbu_pkg::CMD_ADD: data_nxt.direct[i] = sum[8] ? 8'hff : sum[7:0];
        pbu_pkg::CMD_SUB: data_nxt.direct[i] = (db > sb) ? db - sb : 8'd0;
        pbu_pkg::CMD_DARK: data_nxt.direct[i] = (i == 3) ? db : dk[8:1];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  // an accepted transaction is held until taken downstream
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r)
    else $error("operand stage lost a transaction");

endmodule

// File: design/pbu_mult.sv
// Second pipeline stage: two 8x9 products per byte lane, registered.
// Depends on pbu_pkg.
module pbu_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbu_pkg::op_stage_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output pbu_pkg::mul_stage_t out_data
);

  logic                valid_r;
  pbu_pkg::mul_stage_t data_r;
  pbu_pkg::mul_stage_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt        = '0;
    data_nxt.cmd    = in_data.cmd;
    data_nxt.src    = in_data.src;
    data_nxt.dst    = in_data.dst;
    data_nxt.last   = in_data.last;
    data_nxt.direct = in_data.direct;
    for (int i = 0; i < pbu_pkg::LANES; i++) begin
      data_nxt.p0[i] = {9'd0, in_data.x0[i]} * {8'd0, in_data.y0[i]};
      data_nxt.p1[i] = {9'd0, in_data.x1[i]} * {8'd0, in_data.y1[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  // hold products while the combine stage stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(data_r))
    else $error("multiply stage changed while stalled");

endmodule

// File: design/pbu_combine.sv
// Third pipeline stage: shifts, sums and clamps the products per mode and
// registers the final pixel for the output channel. Depends on pbu_pkg.
module pbu_combine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  pbu_pkg::mul_stage_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         result_pixel,
  output logic                last_out
);

  logic        valid_r;
  logic [31:0] result_r;
  logic [31:0] result_nxt;
  logic        last_r;
  logic        in_fire;

  assign in_fire      = in_valid && in_ready;
  assign in_ready     = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign result_pixel = result_r;
  assign last_out     = last_r;

  always_comb begin
    logic [7:0]  sb;
    logic [7:0]  db;
    logic [15:0] p0;
    logic [15:0] p1;
    logic [17:0] msum;
    logic [8:0]  osum;
    logic [9:0]  ex;
    logic [7:0]  r;
    result_nxt = '0;
    for (int i = 0; i < pbu_pkg::LANES; i++) begin
      sb   = in_data.src[8*i +: 8];
      db   = in_data.dst[8*i +: 8];
      p0   = in_data.p0[i][15:0];
      p1   = in_data.p1[i][15:0];
      msum = {1'b0, in_data.p0[i]} + {1'b0, in_data.p1[i]};
      osum = {1'b0, p0[15:8]} + {1'b0, p1[15:8]};
      ex   = {2'b00, sb} + {2'b00, db} - {1'b0, p0[15:7]};
      unique case (in_data.cmd) inside
        pbu_pkg::CMD_MIX, pbu_pkg::CMD_MIXA, pbu_pkg::CMD_FADE: r = msum[15:8];
        pbu_pkg::CMD_ADD, pbu_pkg::CMD_SUB, pbu_pkg::CMD_DARK: r = in_data.direct[i];
        pbu_pkg::CMD_OVER: begin
          if (i == 3) begin
            r = 8'd0;
          end else begin
            r = osum[8] ? 8'hff : osum[7:0];
          end
        end
        pbu_pkg::CMD_EXCL: r = (i == 3) ? db : ex[7:0];
        pbu_pkg::CMD_SOFT: begin
          if (i == 3) begin
            r = db;
          end else if (!db[7]) begin
            r = p0[14:7];
          end else begin
            r = 8'd255 - p0[14:7];
          end
        end
        pbu_pkg::CMD_MUL, pbu_pkg::CMD_MULA: r = p0[15:8];
        default: r = db;
      endcase
      result_nxt[8*i +: 8] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      result_r <= result_nxt;
      last_r   <= in_data.last;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd == pbu_pkg::CMD_OVER |=> result_r[31:24] == 8'd0)
    else $error("over mode alpha not cleared");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.cmd > pbu_pkg::CMD_FADE |=> result_r == $past(in_data.dst))
    else $error("unused command did not pass destination through");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.cmd == pbu_pkg::CMD_EXCL || in_data.cmd == pbu_pkg::CMD_SOFT ||
                in_data.cmd == pbu_pkg::CMD_DARK)
    |=> result_r[31:24] == $past(in_data.dst[31:24]))
    else $error("destination alpha not kept");

endmodule

// File: design/pixel_blend_unit_core.sv
// Pixel blend unit top level: ARGB8888 blend modes over a valid/ready stream.
// Each transaction passes through the registered operand, multiply and combine stages.
// Throughput: one transaction per cycle; each stage stalls only when full and blocked.
// Reset (synchronous, active low) empties the pipeline and clears mix_alpha and
// fade_color to 0. Depends on pbu_pkg, pbu_if, pbu_operand, pbu_mult, pbu_combine.
module pixel_blend_unit_core (
  input  logic                               clk,
  input  logic                               rst_n,
  pbu_in_if.sink                             in_ch,
  pbu_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [pbu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [7:0]          mix_alpha_r;
  logic [31:0]         fade_color_r;

  pbu_pkg::in_item_t   in_item;
  logic                op_valid;
  logic                op_ready;
  pbu_pkg::op_stage_t  op_data;
  logic                mul_valid;
  logic                mul_ready;
  pbu_pkg::mul_stage_t mul_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_alpha_r  <= 8'd0;
      fade_color_r <= 32'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        pbu_pkg::CFG_IDX_MIX_ALPHA:  mix_alpha_r  <= cfg_wdata[7:0];
        pbu_pkg::CFG_IDX_FADE_COLOR: fade_color_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign in_item.cmd  = in_ch.command;
  assign in_item.src  = in_ch.src_pixel;
  assign in_item.dst  = in_ch.dst_pixel;
  assign in_item.last = in_ch.last_pixel;

  pbu_operand u_operand (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_data    (in_item),
    .mix_alpha  (mix_alpha_r),
    .fade_color (fade_color_r),
    .out_valid  (op_valid),
    .out_ready  (op_ready),
    .out_data   (op_data)
  );

  pbu_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (op_valid),
    .in_ready  (op_ready),
    .in_data   (op_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  pbu_combine u_combine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (mul_valid),
    .in_ready     (mul_ready),
    .in_data      (mul_data),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_pixel (out_ch.result_pixel),
    .last_out     (out_ch.last_out)
  );

endmodule
